### hdl/qrrs_pkg.sv
// ---------------------------------------------------------------------------
// qrrs_pkg: shared constants and types of the quadratic real root solver
// Widths of coefficients, discriminant, square root, quotient and bus fields.
// ---------------------------------------------------------------------------
package qrrs_pkg;

   localparam int COEF_WIDTH   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int ROOT_WIDTH   = 40;
   localparam int STATUS_WIDTH = 2;

   // b^2 - 4ac, exact
   localparam int DISC_WIDTH   = 2 * COEF_WIDTH + 3;
   localparam int DMAG_WIDTH   = 2 * COEF_WIDTH + 1;
   // radicand disc * 2^(2*FRAC_BITS), rounded up to an even width
   localparam int RAD_RAW      = DMAG_WIDTH + 2 * FRAC_BITS;
   localparam int RAD_WIDTH    = ((RAD_RAW + 1) / 2) * 2;
   localparam int SQRT_WIDTH   = RAD_WIDTH / 2;
   localparam int DEN_WIDTH    = COEF_WIDTH + 1;
   localparam int NB_WIDTH     = COEF_WIDTH + FRAC_BITS + 1;
   localparam int NUM_WIDTH    = ((NB_WIDTH > SQRT_WIDTH + 1) ? NB_WIDTH : SQRT_WIDTH + 1) + 1;
   localparam int CMP_WIDTH    = ((NUM_WIDTH > ROOT_WIDTH) ? NUM_WIDTH : ROOT_WIDTH) + 1;

   localparam int REQ_DATA_WIDTH = ((3 * COEF_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS     = STATUS_WIDTH + 2 * ROOT_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELDS + 7) / 8) * 8;

   // input, product, discriminant, square root, numerator, divider stages
   localparam int PIPE_DEPTH = 4 + SQRT_WIDTH + NUM_WIDTH;

   localparam logic [STATUS_WIDTH-1:0] ST_NONE   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DOUBLE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_TWO    = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_AZERO  = 2'd3;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]    status;
      logic                       a_neg;
      logic [DEN_WIDTH-1:0]       den;
      logic signed [NB_WIDTH-1:0] nb;
   } sq_side_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    neg_p;
      logic                    neg_m;
   } dv_side_type;

endpackage

### hdl/quadratic_real_root_solver.sv
// ---------------------------------------------------------------------------
// quadratic_real_root_solver: real roots of a x^2 + b x + c
// Exact discriminant, classification and fixed-point roots with 16 fraction bits.
// ---------------------------------------------------------------------------
// Usage: present a, b and c as one request; one response comes back per request,
// in order. Throughput is one request per clock while responses are accepted. The
// path runs through registers for the coefficients, for b*b and a*c and for the
// discriminant, a stage for each of the 33 bits of the square root, a register for
// both numerators, a stage for each of the 35 quotient bits of the two dividers
// running side by side, and the response register. The whole pipeline holds while a
// response waits unaccepted, so no request is lost or repeated. Status 3 flags a zero
// leading coefficient; roots read zero unless the status says they are real.
module quadratic_real_root_solver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
   input  logic [qrrs_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] root_status, [41:2] root_plus, [81:42] root_minus, rest zero
   output logic [qrrs_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import qrrs_pkg::*;

   localparam logic [CMP_WIDTH-1:0] NEG_LIMIT = CMP_WIDTH'(1) << (ROOT_WIDTH - 1);
   localparam logic [CMP_WIDTH-1:0] POS_LIMIT = NEG_LIMIT - CMP_WIDTH'(1);

   logic en;
   logic valid_ff [PIPE_DEPTH];

   // stage 1: coefficients
   logic signed [COEF_WIDTH-1:0] a1_ff, b1_ff, c1_ff;
   // stage 2: products
   logic signed [2*COEF_WIDTH-1:0] bb2_ff, ac2_ff;
   logic signed [COEF_WIDTH-1:0]   a2_ff, b2_ff;
   // stage 3: discriminant and classification
   logic signed [DISC_WIDTH-1:0] disc_in;
   logic [RAD_WIDTH-1:0]         rad3_in, rad3_ff;
   sq_side_type                  side3_in, side3_ff;
   logic signed [COEF_WIDTH:0]   a_ext;
   logic [COEF_WIDTH:0]          a_mag;
   // square root output
   logic [SQRT_WIDTH-1:0] root_s;
   sq_side_type           side_s;
   // stage 4: numerator magnitudes
   logic signed [NUM_WIDTH-1:0] np_sum, nm_sum;
   logic [NUM_WIDTH-1:0]        magp4_in, magm4_in, magp4_ff, magm4_ff;
   logic [DEN_WIDTH-1:0]        den4_ff;
   dv_side_type                 dside4_in, dside4_ff;
   // divider outputs and aligned side data
   logic [NUM_WIDTH-1:0] qp, qm;
   dv_side_type          dl_ff [NUM_WIDTH];
   dv_side_type          dl_last;
   // response
   logic [ROOT_WIDTH-1:0]   plus_in, minus_in, plus_sat, minus_sat;
   logic                    rsp_tvalid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata_ff;

   // advance everything whenever the response register is free or being drained
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) valid_ff[i] <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
         rsp_tvalid_ff <= valid_ff[PIPE_DEPTH-1];
      end
   end

   // stages 1 and 2: capture coefficients, then the two products
   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= req_tdata[COEF_WIDTH-1:0];
         b1_ff  <= req_tdata[2*COEF_WIDTH-1:COEF_WIDTH];
         c1_ff  <= req_tdata[3*COEF_WIDTH-1:2*COEF_WIDTH];
         bb2_ff <= b1_ff * b1_ff;
         ac2_ff <= a1_ff * c1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
      end
   end

   // stage 3: disc = b^2 - 4ac; classify; build radicand, 2|a| and -b * 2^F
   always_comb begin
      disc_in = DISC_WIDTH'(bb2_ff) - (DISC_WIDTH'(ac2_ff) <<< 2);
      a_ext   = (COEF_WIDTH+1)'(a2_ff);
      a_mag   = a_ext[COEF_WIDTH] ? (COEF_WIDTH+1)'(0) - a_ext : a_ext;
      rad3_in = RAD_WIDTH'(disc_in[DMAG_WIDTH-1:0]) << (2 * FRAC_BITS);
      if (disc_in[DISC_WIDTH-1]) rad3_in = '0;
      side3_in.a_neg = a2_ff[COEF_WIDTH-1];
      side3_in.den   = {a_mag[COEF_WIDTH-1:0], 1'b0};
      side3_in.nb    = -(NB_WIDTH'(b2_ff) <<< FRAC_BITS);
      if (a2_ff == '0)               side3_in.status = ST_AZERO;
      else if (disc_in[DISC_WIDTH-1]) side3_in.status = ST_NONE;
      else if (disc_in == '0)        side3_in.status = ST_DOUBLE;
      else                           side3_in.status = ST_TWO;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad3_ff  <= rad3_in;
         side3_ff <= side3_in;
      end
   end

   qrrs_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .rad_in   (rad3_ff),
      .side_in  (side3_ff),
      .root_out (root_s),
      .side_out (side_s)
   );

   // stage 4: -b*2^F +/- sqrt, split into magnitude and result sign
   always_comb begin
      np_sum   = NUM_WIDTH'(side_s.nb) + $signed(NUM_WIDTH'(root_s));
      nm_sum   = NUM_WIDTH'(side_s.nb) - $signed(NUM_WIDTH'(root_s));
      magp4_in = np_sum[NUM_WIDTH-1] ? NUM_WIDTH'(0) - np_sum : np_sum;
      magm4_in = nm_sum[NUM_WIDTH-1] ? NUM_WIDTH'(0) - nm_sum : nm_sum;
      dside4_in.status = side_s.status;
      dside4_in.neg_p  = np_sum[NUM_WIDTH-1] ^ side_s.a_neg;
      dside4_in.neg_m  = nm_sum[NUM_WIDTH-1] ^ side_s.a_neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         magp4_ff  <= magp4_in;
         magm4_ff  <= magm4_in;
         den4_ff   <= side_s.den;
         dside4_ff <= dside4_in;
      end
   end

   qrrs_div u_div_plus (
      .clock   (clock),
      .en      (en),
      .num_in  (magp4_ff),
      .den_in  (den4_ff),
      .quo_out (qp)
   );

   qrrs_div u_div_minus (
      .clock   (clock),
      .en      (en),
      .num_in  (magm4_ff),
      .den_in  (den4_ff),
      .quo_out (qm)
   );

   // hold status and signs in step with the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff[0] <= dside4_ff;
         for (int j = 1; j < NUM_WIDTH; j++) dl_ff[j] <= dl_ff[j-1];
      end
   end
   assign dl_last = dl_ff[NUM_WIDTH-1];

   // apply sign and saturate to the root range
   always_comb begin
      if (dl_last.neg_p) begin
         if (CMP_WIDTH'(qp) > NEG_LIMIT) plus_sat = ROOT_WIDTH'(NEG_LIMIT);
         else plus_sat = ROOT_WIDTH'(CMP_WIDTH'(0) - CMP_WIDTH'(qp));
      end else begin
         if (CMP_WIDTH'(qp) > POS_LIMIT) plus_sat = ROOT_WIDTH'(POS_LIMIT);
         else plus_sat = ROOT_WIDTH'(CMP_WIDTH'(qp));
      end
      if (dl_last.neg_m) begin
         if (CMP_WIDTH'(qm) > NEG_LIMIT) minus_sat = ROOT_WIDTH'(NEG_LIMIT);
         else minus_sat = ROOT_WIDTH'(CMP_WIDTH'(0) - CMP_WIDTH'(qm));
      end else begin
         if (CMP_WIDTH'(qm) > POS_LIMIT) minus_sat = ROOT_WIDTH'(POS_LIMIT);
         else minus_sat = ROOT_WIDTH'(CMP_WIDTH'(qm));
      end
      // drop roots that are not real for this status
      plus_in  = (dl_last.status == ST_DOUBLE || dl_last.status == ST_TWO) ? plus_sat : '0;
      minus_in = (dl_last.status == ST_TWO) ? minus_sat : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= RSP_DATA_WIDTH'({minus_in, plus_in, dl_last.status});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### hdl/qrrs_sqrt.sv
// ---------------------------------------------------------------------------
// qrrs_sqrt: pipelined integer square root
// One result bit per stage, digit-by-digit restoring method; side data rides along.
// ---------------------------------------------------------------------------
module qrrs_sqrt (
   input  logic                              clock,
   input  logic                              en,
   input  logic [qrrs_pkg::RAD_WIDTH-1:0]    rad_in,
   input  qrrs_pkg::sq_side_type             side_in,
   output logic [qrrs_pkg::SQRT_WIDTH-1:0]   root_out,
   output qrrs_pkg::sq_side_type             side_out
);
   import qrrs_pkg::*;

   localparam int REM_WIDTH = SQRT_WIDTH + 2;

   logic [RAD_WIDTH-1:0]  rad_ff  [SQRT_WIDTH];
   logic [REM_WIDTH-1:0]  rem_ff  [SQRT_WIDTH];
   logic [SQRT_WIDTH-1:0] root_ff [SQRT_WIDTH];
   sq_side_type           side_ff [SQRT_WIDTH];

   genvar k;
   generate
      for (k = 0; k < SQRT_WIDTH; k++) begin : g_stage
         logic [RAD_WIDTH-1:0]  prv_rad;
         logic [REM_WIDTH-1:0]  prv_rem;
         logic [SQRT_WIDTH-1:0] prv_root;
         sq_side_type           prv_side;
         logic [REM_WIDTH-1:0]  remx;
         logic [REM_WIDTH-1:0]  trial;
         logic [REM_WIDTH-1:0]  rem_in;
         logic [SQRT_WIDTH-1:0] root_in;

         if (k == 0) begin : g_first
            assign prv_rad  = rad_in;
            assign prv_rem  = '0;
            assign prv_root = '0;
            assign prv_side = side_in;
         end else begin : g_next
            assign prv_rad  = rad_ff[k-1];
            assign prv_rem  = rem_ff[k-1];
            assign prv_root = root_ff[k-1];
            assign prv_side = side_ff[k-1];
         end

         always_comb begin
            remx  = {prv_rem[REM_WIDTH-3:0], prv_rad[RAD_WIDTH-1 -: 2]};
            trial = {prv_root, 2'b01};
            if (remx >= trial) begin
               rem_in  = remx - trial;
               root_in = {prv_root[SQRT_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = remx;
               root_in = {prv_root[SQRT_WIDTH-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[k]  <= prv_rad << 2;
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               side_ff[k] <= prv_side;
            end
         end
      end
   endgenerate

   assign root_out = root_ff[SQRT_WIDTH-1];
   assign side_out = side_ff[SQRT_WIDTH-1];

endmodule

### hdl/qrrs_div.sv
// ---------------------------------------------------------------------------
// qrrs_div: pipelined unsigned divider
// Restoring long division, one quotient bit per stage.
// ---------------------------------------------------------------------------
module qrrs_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic [qrrs_pkg::NUM_WIDTH-1:0]   num_in,
   input  logic [qrrs_pkg::DEN_WIDTH-1:0]   den_in,
   output logic [qrrs_pkg::NUM_WIDTH-1:0]   quo_out
);
   import qrrs_pkg::*;

   logic [NUM_WIDTH-1:0] num_ff [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] rem_ff [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] quo_ff [NUM_WIDTH];

   genvar j;
   generate
      for (j = 0; j < NUM_WIDTH; j++) begin : g_stage
         logic [NUM_WIDTH-1:0] prv_num;
         logic [DEN_WIDTH-1:0] prv_rem;
         logic [DEN_WIDTH-1:0] prv_den;
         logic [NUM_WIDTH-1:0] prv_quo;
         logic [DEN_WIDTH:0]   remx;
         logic [DEN_WIDTH:0]   diff;
         logic [DEN_WIDTH-1:0] rem_in;
         logic [NUM_WIDTH-1:0] quo_in;

         if (j == 0) begin : g_first
            assign prv_num = num_in;
            assign prv_rem = '0;
            assign prv_den = den_in;
            assign prv_quo = '0;
         end else begin : g_next
            assign prv_num = num_ff[j-1];
            assign prv_rem = rem_ff[j-1];
            assign prv_den = den_ff[j-1];
            assign prv_quo = quo_ff[j-1];
         end

         always_comb begin
            remx = {prv_rem, prv_num[NUM_WIDTH-1]};
            diff = remx - {1'b0, prv_den};
            if (remx >= {1'b0, prv_den}) begin
               rem_in = diff[DEN_WIDTH-1:0];
               quo_in = {prv_quo[NUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = remx[DEN_WIDTH-1:0];
               quo_in = {prv_quo[NUM_WIDTH-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[j] <= prv_num << 1;
               rem_ff[j] <= rem_in;
               den_ff[j] <= prv_den;
               quo_ff[j] <= quo_in;
            end
         end
      end
   endgenerate

   assign quo_out = quo_ff[NUM_WIDTH-1];

endmodule

### hdl/qrrs_checker.sv
// ---------------------------------------------------------------------------
// qrrs_checker: port-level checks of the quadratic real root solver
// Watches the handshakes and the response fields; bound to the top level.
// ---------------------------------------------------------------------------
module qrrs_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [qrrs_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [qrrs_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import qrrs_pkg::*;

   logic [STATUS_WIDTH-1:0] st;
   logic [ROOT_WIDTH-1:0]   rp, rm;

   assign st = rsp_tdata[STATUS_WIDTH-1:0];
   assign rp = rsp_tdata[STATUS_WIDTH+ROOT_WIDTH-1:STATUS_WIDTH];
   assign rm = rsp_tdata[STATUS_WIDTH+2*ROOT_WIDTH-1:STATUS_WIDTH+ROOT_WIDTH];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // requests are taken exactly when the response side can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready out of step with response side");

   // the minus root is zero unless two roots exist
   a_minus_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st != ST_TWO |-> rm == '0)
      else $error("root_minus set without two roots");

   // no real roots or a zero leading coefficient clears the plus root
   a_plus_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (st == ST_NONE || st == ST_AZERO) |-> rp == '0)
      else $error("root_plus set without a real root");

endmodule

bind quadratic_real_root_solver qrrs_checker u_qrrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/quadratic_real_root_solver_tb.sv
// ---------------------------------------------------------------------------
// quadratic_real_root_solver_tb: self-checking bench of the quadratic solver
// Drives coefficient requests with random gaps, predicts status and both
// fixed-point roots per request, and checks every response in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_real_root_solver_tb;
   import qrrs_pkg::*;

   localparam longint ROOT_HI = (64'sd1 <<< (ROOT_WIDTH - 1)) - 1;
   localparam longint ROOT_LO = -ROOT_HI - 1;
   localparam int     N_RANDOM = 1950;
   localparam int     CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]      status;
      logic signed [ROOT_WIDTH-1:0] plus;
      logic signed [ROOT_WIDTH-1:0] minus;
   } roots_type;

   // holds expected roots in request order and compares each response
   class roots_scoreboard;
      roots_type pending[$];
      int        errors;

      // floor(sqrt(d * 2^(2*FRAC_BITS))), bit by bit on wide unsigned words
      static function logic [127:0] fixed_sqrt(logic [63:0] d);
         logic [127:0] rad;
         logic [127:0] r;
         logic [127:0] t;
         rad = {64'd0, d} << (2 * FRAC_BITS);
         r = 0;
         for (int bitpos = 62; bitpos >= 0; bitpos--) begin
            t = r | (128'd1 << bitpos);
            if (t * t <= rad) r = t;
         end
         return r;
      endfunction

      // truncate toward zero, saturate to the root range
      static function logic signed [ROOT_WIDTH-1:0] root_quot(longint num, longint den);
         longint q;
         q = num / den;
         if (q > ROOT_HI) q = ROOT_HI;
         if (q < ROOT_LO) q = ROOT_LO;
         return q[ROOT_WIDTH-1:0];
      endfunction

      function void note_request(logic signed [COEF_WIDTH-1:0] a,
                                 logic signed [COEF_WIDTH-1:0] b,
                                 logic signed [COEF_WIDTH-1:0] c);
         roots_type exp_r;
         longint    la, lb, lc, disc, nb, s, den;
         la = a; lb = b; lc = c;
         exp_r = '0;
         if (la == 0) begin
            exp_r.status = ST_AZERO;
         end else begin
            disc = lb * lb - 4 * la * lc;
            if (disc < 0) begin
               exp_r.status = ST_NONE;
            end else begin
               den = 2 * la;
               nb = -lb * (64'sd1 <<< FRAC_BITS);
               s = longint'(fixed_sqrt(disc[63:0]));
               if (disc == 0) begin
                  exp_r.status = ST_DOUBLE;
                  exp_r.plus = root_quot(nb, den);
               end else begin
                  exp_r.status = ST_TWO;
                  exp_r.plus = root_quot(nb + s, den);
                  exp_r.minus = root_quot(nb - s, den);
               end
            end
         end
         pending.push_back(exp_r);
      endfunction

      function void check_response(logic [RSP_DATA_WIDTH-1:0] data);
         roots_type exp_r;
         roots_type got;
         got.status = data[STATUS_WIDTH-1:0];
         got.plus = data[STATUS_WIDTH +: ROOT_WIDTH];
         got.minus = data[STATUS_WIDTH + ROOT_WIDTH +: ROOT_WIDTH];
         if (pending.size() == 0) begin
            $error("response with no request outstanding: %h", data);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.status !== exp_r.status) begin
            $error("root_status expected %0d actual %0d", exp_r.status, got.status);
            errors++;
         end
         if (got.plus !== exp_r.plus) begin
            $error("root_plus expected %0d actual %0d", exp_r.plus, got.plus);
            errors++;
         end
         if (got.minus !== exp_r.minus) begin
            $error("root_minus expected %0d actual %0d", exp_r.minus, got.minus);
            errors++;
         end
         if (data[RSP_DATA_WIDTH-1:RSP_FIELDS] !== '0) begin
            $error("rsp_tdata padding expected 0 actual %h",
                   data[RSP_DATA_WIDTH-1:RSP_FIELDS]);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [1:0] root_status, [41:2] root_plus, [81:42] root_minus, rest zero
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   roots_scoreboard roots_sb = new();
   int  cycle_count = 0;
   // receiver holds off while this is set (long backpressure phase)
   bit  hold_rsp = 1'b0;

   quadratic_real_root_solver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // note each accepted request, check each accepted response
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_tvalid && req_tready)
         roots_sb.note_request($signed(req_tdata[15:0]), $signed(req_tdata[31:16]),
                               $signed(req_tdata[47:32]));
      if (!reset && rsp_tvalid && rsp_tready)
         roots_sb.check_response(rsp_tdata);
   end

   // give up once the cycle counter runs far past the slowest correct run
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // send one request after a random gap; tvalid stays up after acceptance
   // so back-to-back requests follow without a bubble
   task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_WIDTH'({c, b, a});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // send one request of a randomly chosen coefficient kind; no_gap skips the gap
   task automatic send_random(bit no_gap);
      logic [15:0] a, b, c;
      case ($urandom_range(5))
         0: begin
            // full random range
            a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
         end
         1: begin
            // small coefficients, roots of all kinds
            a = 16'($signed($urandom_range(16)) - 8);
            b = 16'($signed($urandom_range(32)) - 16);
            c = 16'($signed($urandom_range(16)) - 8);
         end
         2: begin
            // perfect square: a (x - r)^2 gives a double root
            int r, k;
            k = $urandom_range(60) - 30;
            if (k == 0) k = 1;
            r = $urandom_range(40) - 20;
            a = 16'(k); b = 16'(-2 * k * r); c = 16'(k * r * r);
         end
         3: begin
            // leading coefficient zero
            a = 0; b = 16'($urandom); c = 16'($urandom);
         end
         4: begin
            // a and c with opposite sign bits: two roots whenever neither a nor c is zero
            a = 16'($urandom); c = 16'($urandom);
            b = 16'($urandom);
            if (a[15] == c[15]) c = ~c;
         end
         default: begin
            // edge values mixed with random ones
            a = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
            b = ($urandom_range(1)) ? 16'($urandom) : 16'h8000;
            c = ($urandom_range(1)) ? 16'h7fff : 16'($urandom);
         end
      endcase
      send_coefs(a, b, c, no_gap);
   endtask

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else begin
            stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
            while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         end
      end
   end

   // count the long hold-off in its own process
   initial begin
      wait (cycle_count == 3000);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int tail;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero leading coefficient, each root class, field extremes
      send_coefs(16'd0, 16'd5, 16'd3, 1'b0);
      send_coefs(16'd0, 16'd0, 16'd0, 1'b0);
      send_coefs(16'd1, 16'd0, 16'd1, 1'b0);       // no real roots
      send_coefs(16'd1, 16'hfffe, 16'd1, 1'b0);    // double root at 1
      send_coefs(16'd1, 16'hfffd, 16'd2, 1'b0);    // roots 1 and 2
      send_coefs(16'hffff, 16'd0, 16'd4, 1'b0);    // negative a
      send_coefs(16'd3, 16'd1, 16'hfffe, 1'b0);    // fractional roots
      send_coefs(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
      send_coefs(16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_coefs(16'h8000, 16'h7fff, 16'h7fff, 1'b0);
      send_coefs(16'h7fff, 16'h8000, 16'h8000, 1'b0);
      send_coefs(16'd1, 16'h8000, 16'h8000, 1'b0);  // most negative b, two roots
      send_coefs(16'd1, 16'h8000, 16'h4000, 1'b0);  // most negative b, positive c, two roots
      send_coefs(16'hffff, 16'h8000, 16'hc000, 1'b0);
      send_coefs(16'h0001, 16'h7fff, 16'h0000, 1'b0);
      send_coefs(16'hffff, 16'hffff, 16'hffff, 1'b0);
      send_coefs(16'h5555, 16'haaaa, 16'h5555, 1'b0);
      send_coefs(16'haaaa, 16'h5555, 16'haaaa, 1'b0);
      req_tvalid <= 1'b0;

      // pause until every expected response has drained
      wait (roots_sb.pending.size() == 0);

      for (int i = 0; i < N_RANDOM; i++) begin
         // run bursts without gaps now and then
         send_random((i % 200) >= 150);
      end
      req_tvalid <= 1'b0;

      tail = 0;
      while (roots_sb.pending.size() != 0) @(posedge clock);
      while (tail < PIPE_DEPTH + 20) begin
         @(posedge clock);
         tail++;
      end
      if (roots_sb.errors == 0 && roots_sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
